FILE: rtl/cbr_pkg.sv
// Shared constants, codes and types of the channel busy ratio meter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

  // Width of one free-running time counter and of each delta.
  localparam int CNT_W = 64;
  // Digit handled per cycle by the serial subtractors.
  localparam int DIGIT_W = 8;
  localparam int NUM_DIGITS = CNT_W / DIGIT_W;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  // Counter lanes: active, busy, receive, transmit.
  localparam int NUM_LANES = 4;
  localparam int LANE_ACTIVE = 0;
  localparam int LANE_BUSY = 1;
  localparam int LANE_RECEIVE = 2;
  localparam int LANE_TRANSMIT = 3;

  // Result fields.
  localparam int STATUS_W = 3;
  localparam int RATIO_W = 17;
  localparam int RATIO_FRAC_BITS_DEF = 16;

  // Stream widths.
  localparam int IN_TDATA_W = NUM_LANES * CNT_W;
  localparam int OUT_TDATA_W = 280;
  localparam int OUT_PAD_W = OUT_TDATA_W - RATIO_W - NUM_LANES * CNT_W;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_BASELINE  = 3'd0,
    STAT_IGNORED   = 3'd1,
    STAT_WRAPPED   = 3'd2,
    STAT_VALID     = 3'd3,
    STAT_NO_ACTIVE = 3'd4
  } cbr_status_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } cbr_state_t;

endpackage

`default_nettype wire

FILE: rtl/channel_busy_ratio_meter.sv
// Top level of the channel busy ratio meter: stream ports, serial counter
// subtraction, decision sequencer and output register. Uses cbr_pkg and cbr_frac_div.
`timescale 1ns / 1ps
`default_nettype none

// The meter takes one survey sample at a time and returns exactly one result
// per sample. A sample for a channel that is not in use goes from acceptance
// straight to the output state. Any other sample runs its four counters
// through byte-wide serial subtractors, one digit at a time over the 64 bits,
// then passes through the decision state; when a true fraction is needed the
// restoring divider works out the quotient bit by bit and hands it back. The
// input is ready again once the result sits in the output register, so a new
// sample can be accepted while the previous result still waits on out_tready.
module channel_busy_ratio_meter #(
  parameter int RATIO_FRAC_BITS = cbr_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [63:0] active_time, [127:64] busy_time, [191:128] receive_time,
  // [255:192] transmit_time
  input  wire logic [cbr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] channel_in_use
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [16:0] ratio_q16, [80:17] active_delta, [144:81] busy_delta,
  // [208:145] receive_delta, [272:209] transmit_delta, [279:273] zero
  output logic [cbr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [2:0] status
  output logic [cbr_pkg::STATUS_W-1:0]          out_tuser
);

  localparam int RFULL_W = RATIO_FRAC_BITS + 1;
  localparam int EXT_W = (RFULL_W > cbr_pkg::RATIO_W) ? RFULL_W : cbr_pkg::RATIO_W;
  localparam int CW = cbr_pkg::CNT_W;
  localparam int DW = cbr_pkg::DIGIT_W;

  cbr_pkg::cbr_state_t  state_r, state_nxt;
  cbr_pkg::cbr_status_t status_r, status_nxt;
  logic                 first_pending_r, first_pending_nxt;
  logic [cbr_pkg::DIGIT_IDX_W-1:0] digit_r, digit_nxt;

  // Per-lane serial subtraction state.
  logic [CW-1:0] smp_r   [cbr_pkg::NUM_LANES];
  logic [CW-1:0] base_r  [cbr_pkg::NUM_LANES];
  logic [CW-1:0] delta_r [cbr_pkg::NUM_LANES];
  logic [cbr_pkg::NUM_LANES-1:0] brw_r, brw_nxt;
  logic          cmp_brw_r, cmp_brw_nxt;
  logic          act_nz_r, act_nz_nxt;

  logic [DW:0]   lane_dif [cbr_pkg::NUM_LANES];
  logic [DW:0]   cmp_dif;

  logic [RFULL_W-1:0] ratio_r, ratio_nxt;
  logic [EXT_W-1:0]   ratio_ext;

  logic in_accept, sub_step, div_start, out_load;
  logic div_done;
  logic [RATIO_FRAC_BITS-1:0] div_quo;

  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [cbr_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  cbr_pkg::cbr_status_t           out_status_r;
  logic                           show_delta;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == cbr_pkg::ST_IDLE);

  // One digit of sample minus baseline per lane, plus busy minus active delta.
  always_comb begin
    for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
      lane_dif[k] = {1'b0, smp_r[k][DW-1:0]} - {1'b0, base_r[k][DW-1:0]}
                    - {{DW{1'b0}}, brw_r[k]};
    end
    cmp_dif = {1'b0, lane_dif[cbr_pkg::LANE_BUSY][DW-1:0]}
              - {1'b0, lane_dif[cbr_pkg::LANE_ACTIVE][DW-1:0]}
              - {{DW{1'b0}}, cmp_brw_r};
  end

  // Sequencer: next state and the flags that steer the datapath.
  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    first_pending_nxt = first_pending_r;
    digit_nxt = digit_r;
    ratio_nxt = ratio_r;
    brw_nxt = brw_r;
    cmp_brw_nxt = cmp_brw_r;
    act_nz_nxt = act_nz_r;
    sub_step = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      cbr_pkg::ST_IDLE: begin
        if (in_accept) begin
          digit_nxt = '0;
          brw_nxt = '0;
          cmp_brw_nxt = 1'b0;
          act_nz_nxt = 1'b0;
          ratio_nxt = '0;
          if (in_tuser) begin
            state_nxt = cbr_pkg::ST_SUB;
          end else begin
            status_nxt = cbr_pkg::STAT_IGNORED;
            state_nxt = cbr_pkg::ST_OUT;
          end
        end
      end
      cbr_pkg::ST_SUB: begin
        sub_step = 1'b1;
        for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
          brw_nxt[k] = lane_dif[k][DW];
        end
        cmp_brw_nxt = cmp_dif[DW];
        act_nz_nxt = act_nz_r || (|lane_dif[cbr_pkg::LANE_ACTIVE][DW-1:0]);
        digit_nxt = digit_r + 1'b1;
        if (digit_r == cbr_pkg::DIGIT_IDX_W'(cbr_pkg::NUM_DIGITS - 1)) begin
          state_nxt = cbr_pkg::ST_EVAL;
        end
      end
      cbr_pkg::ST_EVAL: begin
        state_nxt = cbr_pkg::ST_OUT;
        priority if (first_pending_r) begin
          first_pending_nxt = 1'b0;
          status_nxt = cbr_pkg::STAT_BASELINE;
        end else if (|brw_r) begin
          status_nxt = cbr_pkg::STAT_WRAPPED;
        end else if (!act_nz_r) begin
          status_nxt = cbr_pkg::STAT_NO_ACTIVE;
        end else if (!cmp_brw_r) begin
          // Busy time at least the active time: clamp to one.
          status_nxt = cbr_pkg::STAT_VALID;
          ratio_nxt = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
        end else begin
          status_nxt = cbr_pkg::STAT_VALID;
          div_start = 1'b1;
          state_nxt = cbr_pkg::ST_DIV;
        end
      end
      cbr_pkg::ST_DIV: begin
        if (div_done) begin
          ratio_nxt = {1'b0, div_quo};
          state_nxt = cbr_pkg::ST_OUT;
        end
      end
      cbr_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = cbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cbr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the request is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control and baseline registers. Baselines reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbr_pkg::ST_IDLE;
      status_r <= cbr_pkg::STAT_BASELINE;
      first_pending_r <= 1'b1;
      digit_r <= '0;
      brw_r <= '0;
      cmp_brw_r <= 1'b0;
      act_nz_r <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
        base_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      first_pending_r <= first_pending_nxt;
      digit_r <= digit_nxt;
      brw_r <= brw_nxt;
      cmp_brw_r <= cmp_brw_nxt;
      act_nz_r <= act_nz_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      // The baseline rotates out its low digit and takes the sample's digit.
      if (sub_step) begin
        for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
          base_r[k] <= {smp_r[k][DW-1:0], base_r[k][CW-1:DW]};
        end
      end
    end
  end

  // Sample and delta shift registers, and the ratio holding register.
  always_ff @(posedge clk) begin
    ratio_r <= ratio_nxt;
    if (in_accept) begin
      for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
        smp_r[k] <= in_tdata[k*CW +: CW];
      end
    end else if (sub_step) begin
      for (int k = 0; k < cbr_pkg::NUM_LANES; k++) begin
        smp_r[k] <= {{DW{1'b0}}, smp_r[k][CW-1:DW]};
        delta_r[k] <= {lane_dif[k][DW-1:0], delta_r[k][CW-1:DW]};
      end
    end
  end

  cbr_frac_div #(
    .FRAC_BITS (RATIO_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (delta_r[cbr_pkg::LANE_BUSY]),
    .divisor  (delta_r[cbr_pkg::LANE_ACTIVE]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result register; fields outside their status are forced to zero.
  assign ratio_ext = EXT_W'(ratio_r);
  assign show_delta = (status_r == cbr_pkg::STAT_VALID) ||
                      (status_r == cbr_pkg::STAT_NO_ACTIVE);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_tdata_r <= {
        {cbr_pkg::OUT_PAD_W{1'b0}},
        show_delta ? delta_r[cbr_pkg::LANE_TRANSMIT] : {CW{1'b0}},
        show_delta ? delta_r[cbr_pkg::LANE_RECEIVE] : {CW{1'b0}},
        show_delta ? delta_r[cbr_pkg::LANE_BUSY] : {CW{1'b0}},
        show_delta ? delta_r[cbr_pkg::LANE_ACTIVE] : {CW{1'b0}},
        (status_r == cbr_pkg::STAT_VALID) ? ratio_ext[cbr_pkg::RATIO_W-1:0]
                                          : {cbr_pkg::RATIO_W{1'b0}}
      };
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_status_r;

endmodule

`default_nettype wire

FILE: rtl/cbr_frac_div.sv
// Restoring divider that produces one fraction bit of busy/active per cycle.
// Uses cbr_pkg for the counter width; instantiated by the meter top level.
`timescale 1ns / 1ps
`default_nettype none

module cbr_frac_div #(
  parameter int FRAC_BITS = cbr_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cbr_pkg::CNT_W-1:0]  dividend,
  input  wire logic [cbr_pkg::CNT_W-1:0]  divisor,
  output logic                            done,
  output logic [FRAC_BITS-1:0]            quotient
);

  localparam int STEP_W = $clog2(FRAC_BITS);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [cbr_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [cbr_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [FRAC_BITS-1:0]       quo_r, quo_nxt;

  logic [cbr_pkg::CNT_W:0]    shifted;
  logic [cbr_pkg::CNT_W:0]    trial;

  // One restoring step: shift the remainder in, subtract the divisor if it fits.
  always_comb begin
    shifted = {rem_r, 1'b0};
    trial = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    quo_nxt = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt = dividend;
      dvs_nxt = divisor;
      quo_nxt = '0;
    end else if (busy_r) begin
      if (!trial[cbr_pkg::CNT_W]) begin
        rem_nxt = trial[cbr_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[cbr_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath flops.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/cbr_checker.sv
// Port-level checks of the channel busy ratio meter, bound to its top level.
// Uses cbr_pkg for the status codes and field widths.
`timescale 1ns / 1ps
`default_nettype none

module cbr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cbr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [cbr_pkg::STATUS_W-1:0]     out_tuser
);

  localparam int CW = cbr_pkg::CNT_W;
  localparam int RW = cbr_pkg::RATIO_W;

  // A stalled result request stays valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result request keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Samples are handled one at a time: no acceptance in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A nonzero ratio only comes with a valid ratio status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[RW-1:0] != '0) |-> (out_tuser == cbr_pkg::STAT_VALID))
    else $error("ratio reported without valid status");

  // Deltas are zero unless the status reports them.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != cbr_pkg::STAT_VALID) &&
    (out_tuser != cbr_pkg::STAT_NO_ACTIVE)
    |-> (out_tdata[RW + 4*CW - 1:RW] == '0))
    else $error("deltas reported with baseline, ignored or wrapped status");

endmodule

bind channel_busy_ratio_meter cbr_checker u_cbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: test/channel_busy_ratio_meter_tb.sv
// Self-checking testbench of the channel busy ratio meter: a directed table of survey
// samples and a long run of random counter sequences, checked against a local predictor.
// Depends on cbr_pkg and channel_busy_ratio_meter.
`timescale 1ns / 1ps

module channel_busy_ratio_meter_tb;

  localparam int FRAC = cbr_pkg::RATIO_FRAC_BITS_DEF;
  localparam int RANDOM_SAMPLES = 1030;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CNT_W = cbr_pkg::CNT_W;
  localparam int NUM_LANES = cbr_pkg::NUM_LANES;
  localparam int RATIO_W = cbr_pkg::RATIO_W;
  localparam logic [CNT_W-1:0] MAXC = {CNT_W{1'b1}};

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic in_use;
    logic [NUM_LANES-1:0][CNT_W-1:0] cnt;
  } survey_t;

  typedef struct packed {
    cbr_pkg::cbr_status_t status;
    logic [RATIO_W-1:0] ratio;
    logic [NUM_LANES-1:0][CNT_W-1:0] delta;
  } ratio_result_t;

  typedef struct packed {
    survey_t s;
    logic typed;
    ratio_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [cbr_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [cbr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [cbr_pkg::STATUS_W-1:0] out_tuser;

  // Predictor state: first-sample flag and the four baselines.
  logic meter_first = 1'b1;
  logic [NUM_LANES-1:0][CNT_W-1:0] base_cnt = '0;

  ratio_result_t expected_results[$];
  int fail_count = 0;
  int stall_cycles = 0;
  int send_idle = 36;
  int recv_idle = 47;
  string lane_name[NUM_LANES] = '{"active_delta", "busy_delta", "receive_delta",
                                  "transmit_delta"};

  channel_busy_ratio_meter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic count_t rand64();
    return {$urandom, $urandom};
  endfunction

  // A random share of d, from none of it up to nearly all of it.
  function automatic count_t part_of(count_t d);
    logic [2*CNT_W-1:0] prod;
    prod = {{CNT_W{1'b0}}, d} * $urandom_range(0, 65535);
    return prod[CNT_W+15:16];
  endfunction

  // Expected result of one survey sample; advances the baselines.
  function automatic ratio_result_t predict_ratio(survey_t s);
    ratio_result_t r;
    logic backwards;
    logic [2*CNT_W-1:0] scaled;
    logic [2*CNT_W-1:0] quo;
    r = '0;
    backwards = 1'b0;
    if (!s.in_use) begin
      r.status = cbr_pkg::STAT_IGNORED;
    end else if (meter_first) begin
      meter_first = 1'b0;
      base_cnt = s.cnt;
      r.status = cbr_pkg::STAT_BASELINE;
    end else begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (s.cnt[l] < base_cnt[l]) backwards = 1'b1;
      end
      if (backwards) begin
        r.status = cbr_pkg::STAT_WRAPPED;
      end else begin
        for (int l = 0; l < NUM_LANES; l++) r.delta[l] = s.cnt[l] - base_cnt[l];
        if (r.delta[cbr_pkg::LANE_ACTIVE] == '0) begin
          r.status = cbr_pkg::STAT_NO_ACTIVE;
        end else begin
          r.status = cbr_pkg::STAT_VALID;
          if (r.delta[cbr_pkg::LANE_BUSY] >= r.delta[cbr_pkg::LANE_ACTIVE]) begin
            quo = 1;
            quo = quo << FRAC;
          end else begin
            scaled = {{CNT_W{1'b0}}, r.delta[cbr_pkg::LANE_BUSY]} << FRAC;
            quo = scaled / {{CNT_W{1'b0}}, r.delta[cbr_pkg::LANE_ACTIVE]};
          end
          r.ratio = quo[RATIO_W-1:0];
        end
      end
      base_cnt = s.cnt;
    end
    return r;
  endfunction

  function automatic stim_row_t dir_row(logic u, count_t a, count_t b, count_t rx, count_t tx,
                                        logic typed, cbr_pkg::cbr_status_t st,
                                        logic [RATIO_W-1:0] q,
                                        count_t da, count_t db, count_t dr, count_t dt);
    stim_row_t row;
    row.s.in_use = u;
    row.s.cnt = {tx, rx, b, a};
    row.typed = typed;
    row.want.status = st;
    row.want.ratio = q;
    row.want.delta = {dt, dr, db, da};
    return row;
  endfunction

  // Offer one request, wait for its acceptance and record what it should produce.
  task automatic send_sample(survey_t s, logic typed, ratio_result_t want);
    ratio_result_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= s.in_use;
    in_tdata <= s.cnt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_ratio(s);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    ratio_result_t got;
    ratio_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = cbr_pkg::cbr_status_t'(out_tuser);
      got.ratio = out_tdata[RATIO_W-1:0];
      got.delta = out_tdata[RATIO_W +: NUM_LANES*CNT_W];
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d", out_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
        if (got.ratio !== want.ratio) begin
          $error("ratio_q16: expected %0d, got %0d", want.ratio, got.ratio);
          fail_count++;
        end
        for (int l = 0; l < NUM_LANES; l++) begin
          if (got.delta[l] !== want.delta[l]) begin
            $error("%s: expected %0h, got %0h", lane_name[l], want.delta[l], got.delta[l]);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no request moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    logic [NUM_LANES-1:0][CNT_W-1:0] dev;
    survey_t s;
    count_t da;
    count_t db;
    int pick;
    int sz;
    int lane;
    int samples_sent;

    // Directed table. Rows with a typed result are checked against it; the others
    // are checked against the predictor.
    dir_rows.push_back(dir_row(0, MAXC, MAXC, MAXC, MAXC, 1, cbr_pkg::STAT_IGNORED,
                               0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 100, 50, 10, 5, 1, cbr_pkg::STAT_BASELINE, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 200, 100, 20, 10, 1, cbr_pkg::STAT_VALID, 32768,
                               100, 50, 10, 5));
    // No active time passed, other counters moved.
    dir_rows.push_back(dir_row(1, 200, 110, 30, 15, 1, cbr_pkg::STAT_NO_ACTIVE, 0,
                               0, 10, 10, 5));
    // Busy above active clamps to one, busy equal to active gives exactly one.
    dir_rows.push_back(dir_row(1, 300, 300, 30, 15, 1, cbr_pkg::STAT_VALID, 65536,
                               100, 190, 0, 0));
    dir_rows.push_back(dir_row(1, 400, 400, 30, 15, 1, cbr_pkg::STAT_VALID, 65536,
                               100, 100, 0, 0));
    // Each counter going backwards on its own re-baselines.
    dir_rows.push_back(dir_row(1, 399, 400, 30, 15, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 500, 399, 30, 15, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 600, 500, 29, 15, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 700, 600, 30, 14, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    // A sample off channel leaves the baselines alone.
    dir_rows.push_back(dir_row(0, 0, 0, 0, 0, 1, cbr_pkg::STAT_IGNORED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 703, 601, 31, 15, 0, cbr_pkg::STAT_BASELINE, 0, 0, 0, 0, 0));
    // Full-range deltas.
    dir_rows.push_back(dir_row(1, 0, 0, 0, 0, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, MAXC, MAXC, MAXC, MAXC, 1, cbr_pkg::STAT_VALID, 65536,
                               MAXC, MAXC, MAXC, MAXC));
    dir_rows.push_back(dir_row(1, 0, 0, 0, 0, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, MAXC, MAXC - 1, 0, 0, 0, cbr_pkg::STAT_BASELINE,
                               0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, MAXC, MAXC - 1, MAXC, MAXC, 1, cbr_pkg::STAT_NO_ACTIVE, 0,
                               0, 0, MAXC, MAXC));
    dir_rows.push_back(dir_row(1, 0, 0, 0, 0, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, MAXC, 1, 5, 6, 0, cbr_pkg::STAT_BASELINE, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                               64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                               1, cbr_pkg::STAT_IGNORED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 0, 0, 0, 0, 1, cbr_pkg::STAT_WRAPPED, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1,
                               0, cbr_pkg::STAT_BASELINE, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_sample(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);

    // Random part: mostly counters that run forward from the last sample.
    dev = dir_rows[dir_rows.size()-1].s.cnt;
    samples_sent = 0;
    while (samples_sent < RANDOM_SAMPLES) begin
      if (samples_sent < RANDOM_SAMPLES / 3) begin
        send_idle = 36;
        recv_idle = 47;
      end else if (samples_sent < 2 * RANDOM_SAMPLES / 3) begin
        send_idle = 47;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(0, 99);
      s.in_use = 1'b1;
      if (pick < 8) begin
        s.in_use = 1'b0;
        s.cnt = {rand64(), rand64(), rand64(), rand64()};
      end else if (pick < 12) begin
        lane = $urandom_range(0, NUM_LANES - 1);
        dev[lane] = dev[lane] - count_t'($urandom_range(1, 5000));
        s.cnt = dev;
      end else if (pick < 15) begin
        dev = {rand64(), rand64(), rand64(), rand64()};
        s.cnt = dev;
      end else if (pick < 17) begin
        // Jump close to the top of the counter range.
        for (int l = 0; l < NUM_LANES; l++) dev[l] = MAXC - count_t'($urandom_range(0, 100000));
        s.cnt = dev;
      end else begin
        sz = $urandom_range(0, 99);
        if (pick < 22) da = '0;
        else if (sz < 60) da = count_t'($urandom_range(1, 5000));
        else if (sz < 85) da = {32'd0, $urandom};
        else da = rand64() >> $urandom_range(0, 8);
        sz = $urandom_range(0, 99);
        if (sz < 70) db = part_of(da);
        else if (sz < 85) db = da + count_t'($urandom_range(0, 3));
        else db = count_t'($urandom_range(0, 5000));
        dev[cbr_pkg::LANE_ACTIVE] = dev[cbr_pkg::LANE_ACTIVE] + da;
        dev[cbr_pkg::LANE_BUSY] = dev[cbr_pkg::LANE_BUSY] + db;
        dev[cbr_pkg::LANE_RECEIVE] = dev[cbr_pkg::LANE_RECEIVE] + part_of(da);
        dev[cbr_pkg::LANE_TRANSMIT] = dev[cbr_pkg::LANE_TRANSMIT] + part_of(da);
        s.cnt = dev;
      end
      send_sample(s, 1'b0, '0);
      samples_sent++;
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
